/* sv/ttw_pkg.sv */
// ----------------------------------------------------------------------------
// ttw_pkg: shared types and constants of the text terminal writer
// Command codes, sequencer states, character codes and the word structs that
// pass between the top level and the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package ttw_pkg;

    // Default screen geometry.
    localparam int COLUMNS_DEFAULT = 64;
    localparam int ROWS_DEFAULT    = 50;

    // Character codes and colors.
    localparam logic [7:0] NL_CODE          = 8'd10;
    localparam logic [7:0] CR_CODE          = 8'd13;
    localparam logic [7:0] SPACE_CODE       = 8'd32;
    localparam logic [7:0] FILL_COLOR       = 8'd63;
    localparam logic [7:0] TEXT_COLOR_RESET = 8'd63;

    // Command kinds.
    typedef enum logic [1:0] {
        KIND_PUT     = 2'd0,
        KIND_SET_ROW = 2'd1,
        KIND_SET_COL = 2'd2,
        KIND_READ    = 2'd3
    } kind_t;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_LIN,
        S_MAP,
        S_WRITE,
        S_SCROLL,
        S_RD_ISSUE,
        S_RD_WAIT,
        S_DONE
    } state_t;

    // One command word.
    typedef struct packed {
        kind_t       kind;
        logic [7:0]  char_code;
        logic [6:0]  position;
        logic [11:0] cell_address;
    } req_t;

    // One result word.
    typedef struct packed {
        logic [5:0] cursor_row;
        logic [6:0] cursor_col;
        logic [7:0] cell_char;
        logic [7:0] cell_color;
        logic       scrolled;
    } res_t;

endpackage

`default_nettype wire

/* sv/ttw_ram.sv */
// ----------------------------------------------------------------------------
// ttw_ram: generic single-write, single-read RAM
// One write port and one read port with the read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module ttw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 3200
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

/* sv/ttw_seq.sv */
// ----------------------------------------------------------------------------
// ttw_seq: command sequencer of the text terminal writer
// Keeps the cursor and the row base of the circular cell store, and steps
// each command through address mapping, cell writes, reads and row fills.
// ----------------------------------------------------------------------------
`default_nettype none

module ttw_seq #(
    parameter int COLUMNS = ttw_pkg::COLUMNS_DEFAULT,
    parameter int ROWS    = ttw_pkg::ROWS_DEFAULT
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             req_valid,
    input  wire ttw_pkg::req_t                    req,
    input  wire logic [7:0]                       text_color,
    input  wire logic                             res_take,
    output logic                                  idle,
    output logic                                  res_valid,
    output ttw_pkg::res_t                         res,
    output logic                                  mem_we,
    output logic [$clog2(ROWS*COLUMNS)-1:0]       mem_waddr,
    output logic [15:0]                           mem_wdata,
    output logic [$clog2(ROWS*COLUMNS)-1:0]       mem_raddr,
    input  wire logic [15:0]                      mem_rdata
);

    localparam int CELLS = ROWS * COLUMNS;
    localparam int AW    = $clog2(CELLS);
    localparam int RW    = $clog2(ROWS);
    localparam int CW    = $clog2(COLUMNS + 1);
    localparam int FW    = $clog2(COLUMNS);

    localparam logic [AW:0]   CELLS_W   = (AW+1)'(CELLS);
    localparam logic [AW:0]   COLS_W    = (AW+1)'(COLUMNS);
    localparam logic [AW-1:0] COLS_A    = AW'(COLUMNS);
    localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);
    localparam logic [RW-1:0] LAST_ROW  = RW'(ROWS - 1);
    localparam logic [CW-1:0] COL_END   = CW'(COLUMNS);
    localparam logic [FW-1:0] FILL_LAST = FW'(COLUMNS - 1);
    localparam logic [8:0]    ROW_MAX9  = 9'(ROWS - 1);
    localparam logic [8:0]    COL_MAX9  = 9'(COLUMNS);
    localparam logic [16:0]   CELLS_17  = 17'(CELLS);

    ttw_pkg::state_t state_reg, state_next;

    logic [RW-1:0] row_reg, row_next;
    logic [CW-1:0] col_reg, col_next;
    logic [AW-1:0] base_reg, base_next;
    logic [AW-1:0] lin_reg, lin_next;
    logic [AW-1:0] phys_reg, phys_next;
    logic [AW-1:0] fill_addr_reg, fill_addr_next;
    logic [FW-1:0] fill_cnt_reg, fill_cnt_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic          wrap_wr_reg, wrap_wr_next;
    logic          scrolled_reg, scrolled_next;
    logic [7:0]    rc_reg, rc_next;
    logic [7:0]    rcol_reg, rcol_next;
    ttw_pkg::req_t cmd_reg, cmd_next;

    // Shared address arithmetic.
    logic [AW:0]   base_sum;
    logic [AW-1:0] base_adv;
    logic [AW:0]   map_sum;
    logic [AW-1:0] map_phys;
    logic          at_last_row;
    logic          addr_ok;
    logic          is_ctrl_char;

    // Next row base after a scroll, wrapping around the store.
    assign base_sum = {1'b0, base_reg} + COLS_W;
    assign base_adv = (base_sum >= CELLS_W) ? AW'(base_sum - CELLS_W) : AW'(base_sum);

    // Logical cell index to physical address.
    assign map_sum  = {1'b0, lin_reg} + {1'b0, base_reg};
    assign map_phys = (map_sum >= CELLS_W) ? AW'(map_sum - CELLS_W) : AW'(map_sum);

    assign at_last_row  = (row_reg == LAST_ROW);
    assign addr_ok      = ({5'b0, cmd_reg.cell_address} < CELLS_17);
    assign is_ctrl_char = (cmd_reg.char_code == ttw_pkg::NL_CODE)
                       || (cmd_reg.char_code == ttw_pkg::CR_CODE);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ttw_pkg::S_CLEAR:
            begin
                if (clr_reg == LAST_CELL)
                begin
                    state_next = ttw_pkg::S_IDLE;
                end
            end
            ttw_pkg::S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ttw_pkg::S_EXEC;
                end
            end
            ttw_pkg::S_EXEC:
            begin
                unique case (cmd_reg.kind)
                    ttw_pkg::KIND_PUT:
                    begin
                        if (cmd_reg.char_code == ttw_pkg::CR_CODE)
                        begin
                            state_next = ttw_pkg::S_DONE;
                        end
                        else if (cmd_reg.char_code == ttw_pkg::NL_CODE)
                        begin
                            state_next = at_last_row ? ttw_pkg::S_SCROLL : ttw_pkg::S_DONE;
                        end
                        else if (col_reg == COL_END && at_last_row)
                        begin
                            state_next = ttw_pkg::S_SCROLL;
                        end
                        else
                        begin
                            state_next = ttw_pkg::S_LIN;
                        end
                    end
                    ttw_pkg::KIND_SET_ROW, ttw_pkg::KIND_SET_COL:
                    begin
                        state_next = ttw_pkg::S_DONE;
                    end
                    ttw_pkg::KIND_READ:
                    begin
                        state_next = addr_ok ? ttw_pkg::S_MAP : ttw_pkg::S_DONE;
                    end
                endcase
            end
            ttw_pkg::S_LIN:
            begin
                state_next = ttw_pkg::S_MAP;
            end
            ttw_pkg::S_MAP:
            begin
                state_next = (cmd_reg.kind == ttw_pkg::KIND_READ) ? ttw_pkg::S_RD_ISSUE
                                                                  : ttw_pkg::S_WRITE;
            end
            ttw_pkg::S_WRITE:
            begin
                state_next = ttw_pkg::S_DONE;
            end
            ttw_pkg::S_SCROLL:
            begin
                if (fill_cnt_reg == FILL_LAST)
                begin
                    state_next = wrap_wr_reg ? ttw_pkg::S_LIN : ttw_pkg::S_DONE;
                end
            end
            ttw_pkg::S_RD_ISSUE:
            begin
                state_next = ttw_pkg::S_RD_WAIT;
            end
            ttw_pkg::S_RD_WAIT:
            begin
                state_next = ttw_pkg::S_DONE;
            end
            ttw_pkg::S_DONE:
            begin
                if (res_take)
                begin
                    state_next = ttw_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = ttw_pkg::S_IDLE;
            end
        endcase
    end

    // Datapath next values.
    always_comb
    begin
        row_next       = row_reg;
        col_next       = col_reg;
        base_next      = base_reg;
        lin_next       = lin_reg;
        phys_next      = phys_reg;
        fill_addr_next = fill_addr_reg;
        fill_cnt_next  = fill_cnt_reg;
        clr_next       = clr_reg;
        wrap_wr_next   = wrap_wr_reg;
        scrolled_next  = scrolled_reg;
        rc_next        = rc_reg;
        rcol_next      = rcol_reg;
        cmd_next       = cmd_reg;
        unique case (state_reg)
            ttw_pkg::S_CLEAR:
            begin
                clr_next = clr_reg + AW'(1);
            end
            ttw_pkg::S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd_next      = req;
                    scrolled_next = 1'b0;
                    rc_next       = 8'd0;
                    rcol_next     = 8'd0;
                    wrap_wr_next  = 1'b0;
                end
            end
            ttw_pkg::S_EXEC:
            begin
                unique case (cmd_reg.kind)
                    ttw_pkg::KIND_PUT:
                    begin
                        if (cmd_reg.char_code == ttw_pkg::CR_CODE)
                        begin
                            col_next = '0;
                        end
                        else if (cmd_reg.char_code == ttw_pkg::NL_CODE || col_reg == COL_END)
                        begin
                            // Newline, either asked for or caused by a pending wrap.
                            col_next     = '0;
                            wrap_wr_next = !is_ctrl_char;
                            if (at_last_row)
                            begin
                                scrolled_next  = 1'b1;
                                fill_addr_next = base_reg;
                                fill_cnt_next  = '0;
                                base_next      = base_adv;
                            end
                            else
                            begin
                                row_next = row_reg + RW'(1);
                            end
                        end
                    end
                    ttw_pkg::KIND_SET_ROW:
                    begin
                        row_next = ({2'b0, cmd_reg.position} > ROW_MAX9)
                                 ? LAST_ROW : RW'(cmd_reg.position);
                    end
                    ttw_pkg::KIND_SET_COL:
                    begin
                        col_next = ({2'b0, cmd_reg.position} > COL_MAX9)
                                 ? COL_END : CW'(cmd_reg.position);
                    end
                    ttw_pkg::KIND_READ:
                    begin
                        lin_next = AW'(cmd_reg.cell_address);
                    end
                endcase
            end
            ttw_pkg::S_LIN:
            begin
                lin_next = AW'(row_reg) * COLS_A + AW'(col_reg);
            end
            ttw_pkg::S_MAP:
            begin
                phys_next = map_phys;
            end
            ttw_pkg::S_WRITE:
            begin
                col_next = col_reg + CW'(1);
            end
            ttw_pkg::S_SCROLL:
            begin
                fill_addr_next = fill_addr_reg + AW'(1);
                fill_cnt_next  = fill_cnt_reg + FW'(1);
            end
            ttw_pkg::S_RD_ISSUE:
            begin
            end
            ttw_pkg::S_RD_WAIT:
            begin
                rc_next   = mem_rdata[7:0];
                rcol_next = mem_rdata[15:8];
            end
            ttw_pkg::S_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // Outputs and memory port controls.
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = phys_reg;
        mem_wdata = {text_color, cmd_reg.char_code};
        idle      = 1'b0;
        res_valid = 1'b0;
        unique case (state_reg)
            ttw_pkg::S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = 16'd0;
            end
            ttw_pkg::S_IDLE:
            begin
                idle = 1'b1;
            end
            ttw_pkg::S_WRITE:
            begin
                mem_we = 1'b1;
            end
            ttw_pkg::S_SCROLL:
            begin
                mem_we    = 1'b1;
                mem_waddr = fill_addr_reg;
                mem_wdata = {ttw_pkg::FILL_COLOR, ttw_pkg::SPACE_CODE};
            end
            ttw_pkg::S_DONE:
            begin
                res_valid = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // The read address is only sampled in the read issue state.
    assign mem_raddr = phys_reg;

    assign res.cursor_row = 6'(row_reg);
    assign res.cursor_col = 7'(col_reg);
    assign res.cell_char  = rc_reg;
    assign res.cell_color = rcol_reg;
    assign res.scrolled   = scrolled_reg;

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ttw_pkg::S_CLEAR;
            row_reg      <= '0;
            col_reg      <= '0;
            base_reg     <= '0;
            clr_reg      <= '0;
            fill_cnt_reg <= '0;
            wrap_wr_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            row_reg      <= row_next;
            col_reg      <= col_next;
            base_reg     <= base_next;
            clr_reg      <= clr_next;
            fill_cnt_reg <= fill_cnt_next;
            wrap_wr_reg  <= wrap_wr_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        lin_reg       <= lin_next;
        phys_reg      <= phys_next;
        fill_addr_reg <= fill_addr_next;
        scrolled_reg  <= scrolled_next;
        rc_reg        <= rc_next;
        rcol_reg      <= rcol_next;
        cmd_reg       <= cmd_next;
    end

endmodule

`default_nettype wire

/* sv/text_terminal_writer.sv */
// ----------------------------------------------------------------------------
// text_terminal_writer: character-cell text terminal writer
// Writes characters at a cursor into a store of ROWS x COLUMNS cells, handles
// newline, carriage return, wrap and scroll, moves the cursor and reads cells.
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake          | word
//  ---------+-----------+--------------------+--------------------------------
//  in       | input     | in_valid/in_stall  | kind, char_code, position,
//           |           |                    | cell_address
//  out      | output    | out_valid/out_stall| cursor_row, cursor_col,
//           |           |                    | cell_char, cell_color, scrolled
//  cfg      | input     | cfg_write          | cfg_data (text color)
//
// Set-row, set-column and carriage return pass the execute state, a character
// also the index, map and write states, a cell read the map and read states; a
// scroll adds a refill of the freed row through the single write port of the cells.
// Scrolling moves a row base pointer instead of copying rows.
// After reset the cell memory is cleared one cell a cycle, all ROWS*COLUMNS cells
// (3200 at the default size), and no word is accepted until the clear is done.
// A finished result waits in the output register while the next word is
// taken; a second result waits in the sequencer until the register frees.
//
`default_nettype none

module text_terminal_writer #(
    parameter int COLUMNS = ttw_pkg::COLUMNS_DEFAULT,
    parameter int ROWS    = ttw_pkg::ROWS_DEFAULT
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  kind,
    input  wire logic [7:0]  char_code,
    input  wire logic [6:0]  position,
    input  wire logic [11:0] cell_address,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [5:0]       cursor_row,
    output logic [6:0]       cursor_col,
    output logic [7:0]       cell_char,
    output logic [7:0]       cell_color,
    output logic             scrolled,
    input  wire logic        cfg_write,
    input  wire logic [7:0]  cfg_data
);

    localparam int CELLS = ROWS * COLUMNS;
    localparam int AW    = $clog2(CELLS);

    logic          seq_idle;
    logic          seq_res_valid;
    logic          res_take;
    logic          req_valid;
    ttw_pkg::req_t req;
    ttw_pkg::res_t seq_res;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [15:0]   mem_wdata;
    logic [AW-1:0] mem_raddr;
    logic [15:0]   mem_rdata;

    logic          out_valid_reg, out_valid_next;
    ttw_pkg::res_t out_res_reg, out_res_next;
    logic [7:0]    text_color_reg, text_color_next;

    // Input handshake: one word at a time into the sequencer.
    assign in_stall  = !seq_idle;
    assign req_valid = in_valid && !in_stall;

    assign req.kind         = ttw_pkg::kind_t'(kind);
    assign req.char_code    = char_code;
    assign req.position     = position;
    assign req.cell_address = cell_address;

    // Text color register.
    assign text_color_next = cfg_write ? cfg_data : text_color_reg;

    // Output register loads when empty or drained in this cycle.
    assign res_take       = seq_res_valid && (!out_valid_reg || !out_stall);
    assign out_valid_next = res_take || (out_valid_reg && out_stall);
    assign out_res_next   = res_take ? seq_res : out_res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            text_color_reg <= ttw_pkg::TEXT_COLOR_RESET;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            text_color_reg <= text_color_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_res_reg <= out_res_next;
    end

    assign out_valid  = out_valid_reg;
    assign cursor_row = out_res_reg.cursor_row;
    assign cursor_col = out_res_reg.cursor_col;
    assign cell_char  = out_res_reg.cell_char;
    assign cell_color = out_res_reg.cell_color;
    assign scrolled   = out_res_reg.scrolled;

    // Command sequencer.
    ttw_seq #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req        (req),
        .text_color (text_color_reg),
        .res_take   (res_take),
        .idle       (seq_idle),
        .res_valid  (seq_res_valid),
        .res        (seq_res),
        .mem_we     (mem_we),
        .mem_waddr  (mem_waddr),
        .mem_wdata  (mem_wdata),
        .mem_raddr  (mem_raddr),
        .mem_rdata  (mem_rdata)
    );

    // Cell memory: character in the low byte, color in the high byte.
    ttw_ram #(
        .WIDTH (16),
        .DEPTH (CELLS)
    ) u_cells (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    // A scroll always leaves the cursor on the last row.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && scrolled |-> cursor_row == 6'(ROWS - 1))
        else $error("scroll reported with cursor off the last row");

    // The cursor row stays on the screen.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (ROWS > 64) || ({2'b0, cursor_row} < 8'(ROWS)))
        else $error("cursor row beyond the screen");

    // The cursor column never passes the wrap position.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (COLUMNS > 127) || ({2'b0, cursor_col} <= 9'(COLUMNS)))
        else $error("cursor column beyond the wrap position");

    // A result handed over shows up at the output in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_take |=> out_valid)
        else $error("result lost between sequencer and output register");

endmodule

`default_nettype wire

/* dv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench of the text terminal writer
// Drives put-character, set-row, set-column and read-cell words into the block.
// A screen model with its own cell store and cursor predicts every result word,
// and each word that comes out is compared field by field with the oldest
// prediction. The run steps through several text colors and several patterns
// of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

    localparam int COLS        = ttw_pkg::COLUMNS_DEFAULT;
    localparam int LINES       = ttw_pkg::ROWS_DEFAULT;
    localparam int CELL_COUNT  = COLS * LINES;
    localparam int SETTLE      = 100;
    localparam int CYCLE_LIMIT = 400000;

    // Screen model: predicts the result word of every accepted command word.
    class screen_model;
        logic [15:0]   cells [CELL_COUNT];
        int unsigned   row;
        int unsigned   col;
        logic [7:0]    color;
        ttw_pkg::res_t due_words [$];
        int            errors;

        function new();
            foreach (cells[i]) cells[i] = '0;
            row    = 0;
            col    = 0;
            color  = ttw_pkg::TEXT_COLOR_RESET;
            errors = 0;
        endfunction

        // Newline: go to column 0 of the next row, scrolling at the bottom.
        function bit line_feed();
            col = 0;
            if (row + 1 >= LINES)
            begin
                for (int i = 0; i < (LINES - 1) * COLS; i++)
                    cells[i] = cells[i + COLS];
                for (int j = 0; j < COLS; j++)
                    cells[(LINES - 1) * COLS + j] = {ttw_pkg::FILL_COLOR,
                                                     ttw_pkg::SPACE_CODE};
                row = LINES - 1;
                return 1'b1;
            end
            row++;
            return 1'b0;
        endfunction

        // Apply one accepted command word and queue the result it causes.
        function void note_command(ttw_pkg::kind_t k, logic [7:0] ch, logic [6:0] pos,
                                   logic [11:0] addr);
            ttw_pkg::res_t w;
            w = '0;
            case (k)
                ttw_pkg::KIND_PUT:
                begin
                    if (ch == ttw_pkg::NL_CODE)
                        w.scrolled = line_feed();
                    else if (ch == ttw_pkg::CR_CODE)
                        col = 0;
                    else
                    begin
                        // A pending wrap takes a newline before the write.
                        if (col >= COLS)
                            w.scrolled = line_feed();
                        cells[row * COLS + col] = {color, ch};
                        col++;
                    end
                end
                ttw_pkg::KIND_SET_ROW:
                    row = (int'(pos) > LINES - 1) ? LINES - 1 : int'(pos);
                ttw_pkg::KIND_SET_COL:
                    col = (int'(pos) > COLS) ? COLS : int'(pos);
                default:
                begin
                    // Addresses past the store read as zero.
                    if (addr < CELL_COUNT)
                    begin
                        w.cell_char  = cells[addr][7:0];
                        w.cell_color = cells[addr][15:8];
                    end
                end
            endcase
            w.cursor_row = row[5:0];
            w.cursor_col = col[6:0];
            due_words.push_back(w);
        endfunction

        task report(string msg);
            $display("ERROR: %s", msg);
            errors++;
        endtask

        // Compare one result word with the oldest prediction.
        task check_word(ttw_pkg::res_t got);
            ttw_pkg::res_t want;
            bit            bad;
            if (due_words.size() == 0)
            begin
                report($sformatf("unexpected result word row %0d col %0d",
                                 got.cursor_row, got.cursor_col));
                return;
            end
            want = due_words.pop_front();
            bad = (got.cursor_row !== want.cursor_row) ||
                  (got.cursor_col !== want.cursor_col) ||
                  (got.cell_char  !== want.cell_char)  ||
                  (got.cell_color !== want.cell_color) ||
                  (got.scrolled   !== want.scrolled);
            if (bad)
                report($sformatf({"row/col/char/color/scroll expected ",
                                  "%0d/%0d/%02h/%02h/%0b, got %0d/%0d/%02h/%02h/%0b"},
                                 want.cursor_row, want.cursor_col, want.cell_char,
                                 want.cell_color, want.scrolled,
                                 got.cursor_row, got.cursor_col, got.cell_char,
                                 got.cell_color, got.scrolled));
        endtask
    endclass

    logic           clk = 1'b0;
    logic           rst_n;
    logic           in_valid;
    logic           in_stall;
    ttw_pkg::kind_t in_kind;
    logic [7:0]     in_char;
    logic [6:0]     in_pos;
    logic [11:0]    in_addr;
    logic           out_valid;
    logic           out_stall;
    logic [5:0]     cursor_row;
    logic [6:0]     cursor_col;
    logic [7:0]     cell_char;
    logic [7:0]     cell_color;
    logic           scrolled;
    logic           cfg_write;
    logic [7:0]     cfg_data;

    screen_model sb;
    int          idle_pct;
    int          stall_pct;
    int          cycle_count;

    text_terminal_writer dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .kind         (in_kind),
        .char_code    (in_char),
        .position     (in_pos),
        .cell_address (in_addr),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .cursor_row   (cursor_row),
        .cursor_col   (cursor_col),
        .cell_char    (cell_char),
        .cell_color   (cell_color),
        .scrolled     (scrolled),
        .cfg_write    (cfg_write),
        .cfg_data     (cfg_data)
    );

    // Clock with a period of 8.
    always #4 clk = ~clk;

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("text_terminal_writer: mismatch");
            $finish;
        end
    end

    // Receiver stalls, decided anew at every falling edge.
    always @(negedge clk)
        out_stall <= ($urandom_range(99) < stall_pct);

    // Sample both handshakes at the rising edge.
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && in_valid === 1'b1 && in_stall === 1'b0)
            sb.note_command(in_kind, in_char, in_pos, in_addr);
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
            sb.check_word(ttw_pkg::res_t'({cursor_row, cursor_col, cell_char,
                                           cell_color, scrolled}));
    end

    // Present one command word; entered and left at a falling edge.
    task send_word(ttw_pkg::kind_t k, logic [7:0] ch, logic [6:0] pos,
                   logic [11:0] addr);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_kind  <= k;
        in_char  <= ch;
        in_pos   <= pos;
        in_addr  <= addr;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        @(negedge clk);
    endtask

    // Hold the sender back until every predicted word has come out.
    task drain();
        in_valid <= 1'b0;
        @(negedge clk);
        while (sb.due_words.size() != 0)
            @(negedge clk);
    endtask

    // Change the text color while the block is idle.
    task write_color(logic [7:0] value);
        cfg_write <= 1'b1;
        cfg_data  <= value;
        sb.color   = value;
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    // One random command word, biased toward the bottom rows and the right
    // edge so that wraps and scrolls come often.
    task random_word();
        int             sel;
        int             sub;
        ttw_pkg::kind_t k;
        logic [7:0]     ch;
        logic [6:0]     pos;
        logic [11:0]    addr;
        ch   = 8'($urandom_range(255));
        pos  = 7'($urandom_range(127));
        addr = 12'($urandom_range(4095));
        sel  = int'($urandom_range(99));
        sub  = int'($urandom_range(99));
        if (sel < 55)
        begin
            k = ttw_pkg::KIND_PUT;
            if (sub < 14)
                ch = ttw_pkg::NL_CODE;
            else if (sub < 22)
                ch = ttw_pkg::CR_CODE;
        end
        else if (sel < 67)
        begin
            k = ttw_pkg::KIND_SET_ROW;
            if (sub < 50)
                pos = 7'($urandom_range(LINES - 1, LINES - 5));
            else if (sub < 75)
                pos = 7'($urandom_range(LINES - 1));
        end
        else if (sel < 77)
        begin
            k = ttw_pkg::KIND_SET_COL;
            if (sub < 40)
                pos = 7'($urandom_range(COLS, COLS - 8));
            else if (sub < 70)
                pos = 7'($urandom_range(COLS - 1));
        end
        else
        begin
            k = ttw_pkg::KIND_READ;
            if (sub < 50)
                addr = 12'(sb.row * COLS + $urandom_range(COLS - 1));
            else if (sub < 75)
                addr = 12'((LINES - 1) * COLS + $urandom_range(COLS - 1));
            else if (sub < 90)
                addr = 12'($urandom_range(CELL_COUNT - 1));
        end
        send_word(k, ch, pos, addr);
    endtask

    task run_random(int count);
        repeat (count) random_word();
    endtask

    // Short directed sequence: field extremes, every command, wrap, scroll,
    // clamping and reads past the store.
    task directed_words();
        send_word(ttw_pkg::KIND_PUT,     8'h41, 7'd0,   12'd0);
        send_word(ttw_pkg::KIND_PUT,     8'h00, 7'd0,   12'd0);
        send_word(ttw_pkg::KIND_PUT,     8'hFF, 7'd0,   12'd0);
        send_word(ttw_pkg::KIND_READ,    8'h00, 7'd0,   12'd0);
        send_word(ttw_pkg::KIND_READ,    8'h00, 7'd0,   12'd2);
        send_word(ttw_pkg::KIND_SET_COL, 8'h00, 7'd127, 12'd0);
        send_word(ttw_pkg::KIND_PUT,     8'h42, 7'd0,   12'd0);
        send_word(ttw_pkg::KIND_PUT,     ttw_pkg::CR_CODE, 7'd0, 12'd0);
        send_word(ttw_pkg::KIND_SET_COL, 8'h00, 7'd64,  12'd0);
        send_word(ttw_pkg::KIND_PUT,     ttw_pkg::NL_CODE, 7'd0, 12'd0);
        send_word(ttw_pkg::KIND_SET_ROW, 8'h00, 7'd127, 12'd0);
        send_word(ttw_pkg::KIND_SET_ROW, 8'h00, 7'd50,  12'd0);
        send_word(ttw_pkg::KIND_PUT,     8'h43, 7'd0,   12'd0);
        send_word(ttw_pkg::KIND_PUT,     ttw_pkg::NL_CODE, 7'd0, 12'd0);
        send_word(ttw_pkg::KIND_READ,    8'h00, 7'd0,   12'd3136);
        send_word(ttw_pkg::KIND_READ,    8'h00, 7'd0,   12'd3072);
        send_word(ttw_pkg::KIND_READ,    8'h00, 7'd0,   12'd3199);
        send_word(ttw_pkg::KIND_READ,    8'h00, 7'd0,   12'd3200);
        send_word(ttw_pkg::KIND_READ,    8'hFF, 7'd127, 12'd4095);
        send_word(ttw_pkg::KIND_SET_COL, 8'h00, 7'd63,  12'd0);
        send_word(ttw_pkg::KIND_PUT,     8'h44, 7'd0,   12'd0);
        send_word(ttw_pkg::KIND_PUT,     8'h45, 7'd0,   12'd0);
        send_word(ttw_pkg::KIND_SET_ROW, 8'h00, 7'd0,   12'd0);
        send_word(ttw_pkg::KIND_SET_COL, 8'h00, 7'd0,   12'd0);
        send_word(ttw_pkg::KIND_READ,    8'h00, 7'd0,   12'd64);
    endtask

    // Main sequence.
    initial
    begin
        sb          = new();
        idle_pct    = 0;
        stall_pct   = 0;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_kind     = ttw_pkg::KIND_PUT;
        in_char     = '0;
        in_pos      = '0;
        in_addr     = '0;
        cfg_write   = 1'b0;
        cfg_data    = '0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset color, no idling on either side.
        directed_words();
        run_random(100);
        drain();

        // Darkest color, sender idling.
        write_color(8'h00);
        idle_pct  = 49;
        stall_pct = 0;
        run_random(150);
        drain();

        // Brightest color, receiver stalling.
        write_color(8'hFF);
        idle_pct  = 0;
        stall_pct = 49;
        run_random(150);
        drain();

        // Random color, light idling on both sides.
        write_color(8'($urandom_range(255)));
        idle_pct  = 9;
        stall_pct = 9;
        run_random(150);
        drain();

        // Mid color, full rate with one pause until the block is empty.
        write_color(8'h80);
        idle_pct  = 0;
        stall_pct = 0;
        run_random(75);
        drain();
        run_random(75);
        drain();

        repeat (SETTLE) @(posedge clk);
        if (sb.errors == 0)
            $display("text_terminal_writer: match");
        else
            $display("text_terminal_writer: mismatch");
        $finish;
    end

endmodule

`default_nettype wire
